/* src/density_clustering_dbscan_assert.svh */
`ifndef DENSITY_CLUSTERING_DBSCAN_ASSERT_SVH
`define DENSITY_CLUSTERING_DBSCAN_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DBS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define DBS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DBS_ASSERT_IMP(lbl, ante, cons, msg)
`define DBS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* src/dbs_pkg.sv */
`timescale 1ns / 1ps
package dbs_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;

   localparam int IDX_W     = $clog2(MAX_POINTS);
   localparam int CNT_W     = $clog2(MAX_POINTS + 1);
   localparam int LABEL_W   = 7;
   localparam int EPS_W     = 35;
   localparam int MINPTS_W  = 7;
   localparam int RIDX_W    = 6;
   localparam int PT_W      = 3 * COORD_BITS;
   localparam int DIFF_W    = COORD_BITS + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int CMP_W     = (SUM_W > EPS_W) ? SUM_W : EPS_W;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 64;

   localparam logic [EPS_W-1:0]    EPS_RESET    = EPS_W'(256);
   localparam logic [MINPTS_W-1:0] MINPTS_RESET = MINPTS_W'(4);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic REG_EPS    = 1'b0;
   localparam logic REG_MINPTS = 1'b1;

   typedef struct packed {
      logic                         command;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
      logic                         final_point;
      logic [RIDX_W-1:0]            read_index;
   } req_type;

   typedef struct packed {
      logic [RIDX_W-1:0]  point_index;
      logic [LABEL_W-1:0] cluster_id;
      logic [LABEL_W-1:0] cluster_total;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic            valid;
      logic            final_point;
      logic [PT_W-1:0] point;
   } load_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             ref_load;
   } issue_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             near;
      logic             busy;
   } hit_type;

endpackage

/* src/dbs_point_mem.sv */
`timescale 1ns / 1ps
module dbs_point_mem (
   input  logic                     clock,
   input  logic                     we,
   input  logic [dbs_pkg::IDX_W-1:0] waddr,
   input  logic [dbs_pkg::PT_W-1:0]  wdata,
   input  logic [dbs_pkg::IDX_W-1:0] raddr,
   output logic [dbs_pkg::PT_W-1:0]  rdata
);

   logic [dbs_pkg::PT_W-1:0] mem [dbs_pkg::MAX_POINTS];
   logic [dbs_pkg::PT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/dbs_dist.sv */
`timescale 1ns / 1ps
module dbs_dist (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [dbs_pkg::EPS_W-1:0]   eps,
   input  dbs_pkg::issue_type          issue,
   input  logic [dbs_pkg::PT_W-1:0]    rdata,
   output dbs_pkg::hit_type            hit
);

   logic                        v1_ff, v2_ff;
   logic [dbs_pkg::IDX_W-1:0]   q1_ff, q2_ff;
   logic [dbs_pkg::PT_W-1:0]    ref_ff;
   logic [dbs_pkg::SQ_W-1:0]    sq_ff [3];
   logic [dbs_pkg::SQ_W-1:0]    sq_in [3];
   logic [dbs_pkg::SUM_W-1:0]   sum;
   logic [dbs_pkg::CMP_W-1:0]   sum_c, eps_c;

   always_comb begin
      logic signed [dbs_pkg::COORD_BITS-1:0] a, b;
      logic signed [dbs_pkg::DIFF_W-1:0]     d;
      logic signed [dbs_pkg::SQ_W-1:0]       p;
      for (int k = 0; k < 3; k++) begin
         a = rdata[k*dbs_pkg::COORD_BITS +: dbs_pkg::COORD_BITS];
         b = ref_ff[k*dbs_pkg::COORD_BITS +: dbs_pkg::COORD_BITS];
         d = dbs_pkg::DIFF_W'(a) - dbs_pkg::DIFF_W'(b);
         p = d * d;
         sq_in[k] = p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue.valid;
         v2_ff <= v1_ff;
      end
      q1_ff <= issue.idx;
      q2_ff <= q1_ff;
      if (issue.ref_load) begin
         ref_ff <= rdata;
      end
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= sq_in[k];
      end
   end

   // equal points give a zero sum and never count
   assign sum   = dbs_pkg::SUM_W'(sq_ff[0]) + dbs_pkg::SUM_W'(sq_ff[1])
                + dbs_pkg::SUM_W'(sq_ff[2]);
   assign sum_c = dbs_pkg::CMP_W'(sum);
   assign eps_c = dbs_pkg::CMP_W'(eps);

   assign hit.valid = v2_ff;
   assign hit.idx   = q2_ff;
   assign hit.near  = (sum_c != '0) && (sum_c < eps_c);
   assign hit.busy  = v1_ff | v2_ff;

endmodule

/* src/dbs_ctrl.sv */
`timescale 1ns / 1ps
module dbs_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [dbs_pkg::MINPTS_W-1:0]   min_pts,
   input  dbs_pkg::load_type              load,
   input  logic                           rd_en,
   input  logic [dbs_pkg::RIDX_W-1:0]     rd_idx,
   output logic [dbs_pkg::LABEL_W-1:0]    rd_label,
   output logic [dbs_pkg::LABEL_W-1:0]    clusters,
   output logic                           dropped,
   output logic                           busy,
   output logic                           pm_we,
   output logic [dbs_pkg::IDX_W-1:0]      pm_waddr,
   output logic [dbs_pkg::PT_W-1:0]       pm_wdata,
   output logic [dbs_pkg::IDX_W-1:0]      pm_raddr,
   output dbs_pkg::issue_type             issue,
   input  dbs_pkg::hit_type               hit
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_START   = 8'b0000_0010,
      S_REF_RD  = 8'b0000_0100,
      S_REF_CAP = 8'b0000_1000,
      S_SWEEP   = 8'b0001_0000,
      S_DRAIN   = 8'b0010_0000,
      S_SEED    = 8'b0100_0000,
      S_SCAN    = 8'b1000_0000
   } state_type;

   localparam int N = dbs_pkg::MAX_POINTS;
   localparam int IW = dbs_pkg::IDX_W;
   localparam int CW = dbs_pkg::CNT_W;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    dropped_ff, dropped_in;
   logic [dbs_pkg::LABEL_W-1:0] clusters_ff, clusters_in;
   logic                    expand_ff, expand_in;
   logic [IW-1:0]           p_ff, p_in;
   logic [IW-1:0]           q_ff, q_in;
   logic [IW-1:0]           s_ff, s_in;
   logic [CW-1:0]           i_ff, i_in;
   logic [CW-1:0]           nb_ff, nb_in;
   logic [CW-1:0]           pend_ff, pend_in;
   logic [N-1:0]            core_ff, core_in;
   logic [N-1:0]            labeled_ff, labeled_in;
   logic [N-1:0]            pending_ff, pending_in;

   logic                    lw_en;
   logic [IW-1:0]           lw_addr;
   logic [dbs_pkg::LABEL_W-1:0] lw_data;
   logic [IW-1:0]           i_idx;
   logic [IW-1:0]           rd_addr;

   logic [dbs_pkg::LABEL_W-1:0] label_mem [N];
   logic [dbs_pkg::LABEL_W-1:0] lbl_data_ff;
   logic                    lbl_ok_ff;

   assign i_idx = i_ff[IW-1:0];

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      dropped_in  = dropped_ff;
      clusters_in = clusters_ff;
      expand_in   = expand_ff;
      p_in        = p_ff;
      q_in        = q_ff;
      s_in        = s_ff;
      i_in        = i_ff;
      nb_in       = nb_ff;
      pend_in     = pend_ff;
      core_in     = core_ff;
      labeled_in  = labeled_ff;
      pending_in  = pending_ff;
      lw_en       = 1'b0;
      lw_addr     = hit.idx;
      lw_data     = clusters_ff;
      pm_we       = 1'b0;
      pm_raddr    = q_ff;
      issue.valid    = 1'b0;
      issue.idx      = q_ff;
      issue.ref_load = 1'b0;

      if (hit.valid && hit.near) begin
         if (!expand_ff) begin
            nb_in = nb_ff + CW'(1);
         end else if (!labeled_ff[hit.idx]) begin
            labeled_in[hit.idx] = 1'b1;
            lw_en = 1'b1;
            if (core_ff[hit.idx]) begin
               pending_in[hit.idx] = 1'b1;
               pend_in = pend_ff + CW'(1);
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (load.valid) begin
               if (count_ff == '0) begin
                  dropped_in = 1'b0;
               end
               if (count_ff < CW'(N)) begin
                  pm_we = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (load.final_point) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            labeled_in  = '0;
            pending_in  = '0;
            clusters_in = '0;
            expand_in   = 1'b0;
            p_in        = '0;
            if (count_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_REF_RD;
            end
         end
         S_REF_RD: begin
            pm_raddr = p_ff;
            q_in     = '0;
            state_in = S_REF_CAP;
         end
         S_REF_CAP: begin
            issue.ref_load = 1'b1;
            issue.valid    = 1'b1;
            nb_in          = '0;
            q_in           = q_ff + IW'(1);
            if (count_ff == CW'(1)) begin
               state_in = S_DRAIN;
            end else begin
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            issue.valid = 1'b1;
            q_in        = q_ff + IW'(1);
            if (CW'(q_ff) + CW'(1) == count_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!hit.busy) begin
               if (expand_ff) begin
                  state_in = S_SCAN;
               end else begin
                  core_in[p_ff] = (32'(nb_ff) >= 32'(min_pts));
                  if (CW'(p_ff) + CW'(1) == count_ff) begin
                     expand_in = 1'b1;
                     i_in      = '0;
                     state_in  = S_SEED;
                  end else begin
                     p_in     = p_ff + IW'(1);
                     state_in = S_REF_RD;
                  end
               end
            end
         end
         S_SEED: begin
            if (i_ff == count_ff) begin
               count_in = '0;
               state_in = S_IDLE;
            end else if (core_ff[i_idx] && !labeled_ff[i_idx]) begin
               clusters_in         = clusters_ff + dbs_pkg::LABEL_W'(1);
               labeled_in[i_idx]   = 1'b1;
               pending_in[i_idx]   = 1'b1;
               pend_in             = CW'(1);
               lw_en               = 1'b1;
               lw_addr             = i_idx;
               lw_data             = clusters_ff + dbs_pkg::LABEL_W'(1);
               s_in                = '0;
               state_in            = S_SCAN;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         S_SCAN: begin
            if (pend_ff == '0) begin
               i_in     = i_ff + CW'(1);
               state_in = S_SEED;
            end else if (pending_ff[s_ff]) begin
               pending_in[s_ff] = 1'b0;
               pend_in          = pend_ff - CW'(1);
               p_in             = s_ff;
               state_in         = S_REF_RD;
            end else if (CW'(s_ff) + CW'(1) == count_ff) begin
               s_in = '0;
            end else begin
               s_in = s_ff + IW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
         clusters_ff <= '0;
         expand_ff   <= 1'b0;
         labeled_ff  <= '0;
         pending_ff  <= '0;
         pend_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
         clusters_ff <= clusters_in;
         expand_ff   <= expand_in;
         labeled_ff  <= labeled_in;
         pending_ff  <= pending_in;
         pend_ff     <= pend_in;
      end
      p_ff    <= p_in;
      q_ff    <= q_in;
      s_ff    <= s_in;
      i_ff    <= i_in;
      nb_ff   <= nb_in;
      core_ff <= core_in;
   end

   assign rd_addr = IW'(rd_idx);

   always_ff @(posedge clock) begin
      if (lw_en) begin
         label_mem[lw_addr] <= lw_data;
      end
      if (rd_en) begin
         lbl_data_ff <= label_mem[rd_addr];
         lbl_ok_ff   <= labeled_ff[rd_addr] && (32'(rd_idx) < N);
      end
   end

   assign rd_label = lbl_ok_ff ? lbl_data_ff : '0;
   assign clusters = clusters_ff;
   assign dropped  = dropped_ff;
   assign busy     = (state_ff != S_IDLE);
   assign pm_waddr = count_ff[IW-1:0];
   assign pm_wdata = load.point;

endmodule

/* src/density_clustering_dbscan.sv */
`timescale 1ns / 1ps
// Density clustering over up to MAX_POINTS 3-D points.
// req channel: a load item (command 0) writes the next point; the load item
// with final_point set starts a run over the batch. A read item (command 1)
// asks for the label of read_index and yields one rsp item.
// rsp channel: point_index, cluster_id (0 noise), cluster_total, overflow.
// csr port: eps_squared at 0x0, min_pts at 0x8, 64-bit data, no wait states.
// Loads are accepted back to back. A run first counts neighbours of every point
// (one sweep through the point memory per point), then grows each cluster
// with one sweep per core point reached, plus scan steps over the frontier
// bits. req_stall is high for the whole run. A read passes through the
// holding stage into the output register, which gives its rsp item;
// a further item waits while that read is in flight.
// When rsp_stall is high the result holds in the output register; one more
// read item is taken into the holding stage, then req_stall stays high for
// every item until the output drains.
// Reset clears labels (reads give 0), counts and flags, and restores
// eps_squared 256, min_pts 4. Point contents need no clearing.
`include "density_clustering_dbscan_assert.svh"
module density_clustering_dbscan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dbs_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dbs_pkg::rsp_type              rsp_payload,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dbs_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [dbs_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [dbs_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   logic [dbs_pkg::EPS_W-1:0]    eps_ff;
   logic [dbs_pkg::MINPTS_W-1:0] min_ff;
   logic                         csr_wr;

   logic                         req_accept;
   logic                         rd_en;
   dbs_pkg::load_type            load;
   logic [dbs_pkg::LABEL_W-1:0]  rd_label, clusters;
   logic                         dropped, busy;

   logic                         pm_we;
   logic [dbs_pkg::IDX_W-1:0]    pm_waddr, pm_raddr;
   logic [dbs_pkg::PT_W-1:0]     pm_wdata, pm_rdata;
   dbs_pkg::issue_type           issue;
   dbs_pkg::hit_type             hit;

   logic                         s1_valid_ff, s1_valid_in;
   logic [dbs_pkg::RIDX_W-1:0]   s1_idx_ff;
   logic [dbs_pkg::LABEL_W-1:0]  s1_total_ff;
   logic                         s1_ovf_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_load;
   dbs_pkg::rsp_type             rsp_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= dbs_pkg::EPS_RESET;
         min_ff <= dbs_pkg::MINPTS_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[3] == dbs_pkg::REG_EPS) begin
            eps_ff <= csr_pwdata[dbs_pkg::EPS_W-1:0];
         end else begin
            min_ff <= csr_pwdata[dbs_pkg::MINPTS_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[3] == dbs_pkg::REG_MINPTS) ?
                       dbs_pkg::DATA_W'(min_ff) : dbs_pkg::DATA_W'(eps_ff);

   assign req_stall  = busy | s1_valid_ff;
   assign req_accept = req_valid & ~req_stall;
   assign rd_en      = req_accept & (req_payload.command == dbs_pkg::CMD_READ);

   assign load.valid       = req_accept & (req_payload.command == dbs_pkg::CMD_LOAD);
   assign load.final_point = req_payload.final_point;
   assign load.point       = {req_payload.coord_z, req_payload.coord_y,
                              req_payload.coord_x};

   dbs_point_mem u_mem (
      .clock (clock),
      .we    (pm_we),
      .waddr (pm_waddr),
      .wdata (pm_wdata),
      .raddr (pm_raddr),
      .rdata (pm_rdata)
   );

   dbs_dist u_dist (
      .clock (clock),
      .reset (reset),
      .eps   (eps_ff),
      .issue (issue),
      .rdata (pm_rdata),
      .hit   (hit)
   );

   dbs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .min_pts  (min_ff),
      .load     (load),
      .rd_en    (rd_en),
      .rd_idx   (req_payload.read_index),
      .rd_label (rd_label),
      .clusters (clusters),
      .dropped  (dropped),
      .busy     (busy),
      .pm_we    (pm_we),
      .pm_waddr (pm_waddr),
      .pm_wdata (pm_wdata),
      .pm_raddr (pm_raddr),
      .issue    (issue),
      .hit      (hit)
   );

   assign rsp_load     = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign s1_valid_in  = rd_en | (s1_valid_ff & ~rsp_load);
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rd_en) begin
         s1_idx_ff   <= req_payload.read_index;
         s1_total_ff <= clusters;
         s1_ovf_ff   <= dropped;
      end
      if (rsp_load) begin
         rsp_ff.point_index   <= s1_idx_ff;
         rsp_ff.cluster_id    <= rd_label;
         rsp_ff.cluster_total <= s1_total_ff;
         rsp_ff.overflow      <= s1_ovf_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `DBS_ASSERT_IMP(a_no_accept_in_run, busy, req_stall, "item accepted during run")
   `DBS_ASSERT_NXT(a_read_reaches_out, s1_valid_ff, rsp_valid_ff, "read item lost")
   `DBS_ASSERT_NXT(a_final_starts_run, load.valid && load.final_point, busy, "run not started")

endmodule
